>>> rtl/core/jkd_pkg.sv
package jkd_pkg;

  typedef struct packed {
    logic        [15:0] moment_index;
    logic signed [31:0] moment_re;
    logic signed [31:0] moment_im;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] damped_re;
    logic signed [31:0] damped_im;
    logic signed [31:0] kernel_weight;
  } out_beat_t;

  typedef enum logic [7:0] {
    REG_KERNEL_LENGTH = 8'd0,
    REG_PHASE_STEP    = 8'd1,
    REG_COT_STEP      = 8'd2,
    REG_INV_COUNT     = 8'd3
  } reg_idx_t;

  localparam int CORDIC_STEPS = 28;
  localparam logic signed [34:0] CORDIC_GAIN_ONE = 35'sd652032874;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  localparam logic [31:0] ATAN_TBL [0:CORDIC_STEPS-1] = '{
    32'd1073741824, 32'd633866812, 32'd334917814, 32'd170009512, 32'd85334662,
    32'd42708930, 32'd21359676, 32'd10680490, 32'd5340326, 32'd2670174,
    32'd1335088, 32'd667544, 32'd333772, 32'd166886, 32'd83444, 32'd41722,
    32'd20860, 32'd10430, 32'd5216, 32'd2608, 32'd1304, 32'd652, 32'd326,
    32'd162, 32'd82, 32'd40, 32'd20, 32'd10
  };

endpackage

>>> rtl/core/jackson_kernel_damping_unit.sv
// Jackson kernel damping of complex Chebyshev moments. Each beat carries a
// moment and its index m; for m below the kernel length N the moment is scaled
// by the Jackson weight, otherwise it passes through with weight one. The
// datapath is a 37-stage pipeline (phase product, range fold, 28 CORDIC
// iterations, weight multiply chain, output multiply and saturate): it takes
// one beat per cycle while the output is not stalled. The whole pipeline
// holds while the output is stalled. Write the registers only while the
// pipeline is empty.
module jackson_kernel_damping_unit #(
  parameter int MAX_MOMENTS  = 65536,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  jkd_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output jkd_pkg::out_beat_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int NCS  = jkd_pkg::CORDIC_STEPS;
  localparam int LAST = NCS + 8;
  localparam int SAT_BITS = (SAMPLE_WIDTH < 32) ? SAMPLE_WIDTH : 32;
  localparam logic signed [34:0] SAT_HI = (35'sd1 <<< (SAT_BITS - 1)) - 35'sd1;
  localparam logic signed [34:0] SAT_LO = -SAT_HI - 35'sd1;
  localparam logic [24:0] MAX_N = 25'(MAX_MOMENTS);

  typedef struct packed {
    logic               active;
    logic               flip;
    logic        [17:0] nm1;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } side_t;

  function automatic logic signed [31:0] sat(input logic signed [34:0] v);
    if (v > SAT_HI) return 32'(SAT_HI);
    if (v < SAT_LO) return 32'(SAT_LO);
    return 32'(v);
  endfunction

  logic [16:0] kl_r;
  logic [31:0] phase_step_r, cot_step_r, inv_count_r;

  logic [LAST:0] vld_r;
  side_t         side_r [0:LAST];
  logic          adv;

  assign adv       = !(vld_r[LAST] && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kl_r         <= 17'd1;
      phase_step_r <= '0;
      cot_step_r   <= '0;
      inv_count_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        jkd_pkg::REG_KERNEL_LENGTH: kl_r         <= cfg_data[16:0];
        jkd_pkg::REG_PHASE_STEP:    phase_step_r <= cfg_data;
        jkd_pkg::REG_COT_STEP:      cot_step_r   <= cfg_data;
        jkd_pkg::REG_INV_COUNT:     inv_count_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: phase product, index compare
  logic [24:0] n_eff, nm1_w;
  logic [47:0] phase_w;
  side_t       side_nxt;
  logic [32:0] ph_r;

  always_comb begin
    n_eff   = ({8'd0, kl_r} > MAX_N) ? MAX_N : {8'd0, kl_r};
    nm1_w   = n_eff - {9'd0, in_data.moment_index} + 25'd1;
    phase_w = {32'd0, in_data.moment_index} * {16'd0, phase_step_r};
    side_nxt.active = ({9'd0, in_data.moment_index} < n_eff);
    side_nxt.flip   = 1'b0;
    side_nxt.nm1    = nm1_w[17:0];
    side_nxt.re     = in_data.moment_re;
    side_nxt.im     = in_data.moment_im;
  end

  // stage 1: fold phase into [-pi/2, pi/2]
  logic signed [34:0] z_w, zf_w;
  logic               flip_w;
  side_t              side1_w;

  always_comb begin
    z_w    = 35'(signed'(ph_r));
    zf_w   = z_w;
    flip_w = 1'b0;
    if (z_w > 35'sh080000000) begin
      zf_w   = z_w - 35'sh100000000;
      flip_w = 1'b1;
    end else if (z_w < -35'sh080000000) begin
      zf_w   = z_w + 35'sh100000000;
      flip_w = 1'b1;
    end
    side1_w      = side_r[0];
    side1_w.flip = flip_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAST-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_nxt;
      ph_r      <= phase_w[32:0];
      side_r[1] <= side1_w;
      for (int k = 2; k <= LAST; k++) side_r[k] <= side_r[k-1];
    end
  end

  // CORDIC rotation chain
  logic signed [34:0] cx_r [0:NCS];
  logic signed [34:0] cy_r [0:NCS];
  logic signed [34:0] cz_r [0:NCS];

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r[0] <= jkd_pkg::CORDIC_GAIN_ONE;
      cy_r[0] <= '0;
      cz_r[0] <= zf_w;
    end
  end

  for (genvar i = 0; i < NCS; i++) begin : g_cordic
    localparam logic signed [34:0] ATN = 35'(signed'({1'b0, jkd_pkg::ATAN_TBL[i]}));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!cz_r[i][34]) begin
          cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] - ATN;
        end else begin
          cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] + ATN;
        end
      end
    end
  end

  // weight and output chain
  logic signed [34:0] c_r, s_r;
  logic signed [52:0] t1_r, t2_r;
  logic        [53:0] mag_r;
  logic               sgn_r, sgn2_r;
  logic        [53:0] phi_r;
  logic        [31:0] plo_r;
  logic signed [31:0] g_r, g2_r;
  logic        [63:0] pre_r, pim_r;
  logic               nre_r, nim_r;
  jkd_pkg::out_beat_t out_r;

  logic signed [34:0] sabs_w;
  logic        [65:0] t2p_w;
  logic signed [53:0] sum_w;
  logic        [63:0] lop_w;
  logic        [54:0] prod_w;
  logic signed [32:0] gs_w;
  logic signed [31:0] g_nxt;
  logic        [31:0] are_w, aim_w, ag_w;
  logic signed [34:0] dre_w, dim_w;
  side_t              s31, s34, s35, s36;

  assign s31 = side_r[NCS+2];
  assign s34 = side_r[NCS+5];
  assign s35 = side_r[NCS+6];
  assign s36 = side_r[NCS+7];

  always_comb begin
    sabs_w = s_r[34] ? -s_r : s_r;
    t2p_w  = {32'd0, sabs_w[33:0]} * {34'd0, cot_step_r};
    sum_w  = 54'(t1_r) + 54'(t2_r);
    lop_w  = {32'd0, mag_r[31:0]} * {32'd0, inv_count_r};
    prod_w = 55'(phi_r) + 55'(plo_r);
    if (prod_w > 55'h80000000) prod_w = 55'h80000000;
    gs_w   = sgn2_r ? -33'(signed'({1'b0, prod_w[31:0]})) : 33'(signed'({1'b0, prod_w[31:0]}));
    if (gs_w > 33'sh07FFFFFFF) g_nxt = 32'sh7FFFFFFF;
    else g_nxt = 32'(gs_w);
    if (!s34.active) g_nxt = jkd_pkg::ONE_Q30;
    are_w = s35.re[31] ? 32'(-33'(s35.re)) : 32'(s35.re);
    aim_w = s35.im[31] ? 32'(-33'(s35.im)) : 32'(s35.im);
    ag_w  = g_r[31] ? 32'(-33'(g_r)) : 32'(g_r);
    dre_w = nre_r ? -35'(signed'({1'b0, pre_r[63:30]})) : 35'(signed'({1'b0, pre_r[63:30]}));
    dim_w = nim_r ? -35'(signed'({1'b0, pim_r[63:30]})) : 35'(signed'({1'b0, pim_r[63:30]}));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r   <= side_r[NCS+1].flip ? -cx_r[NCS] : cx_r[NCS];
      s_r   <= side_r[NCS+1].flip ? -cy_r[NCS] : cy_r[NCS];
      t1_r  <= 53'(signed'({1'b0, s31.nm1})) * 53'(c_r);
      t2_r  <= s_r[34] ? -53'(signed'({1'b0, t2p_w[65:16]}))
                       :  53'(signed'({1'b0, t2p_w[65:16]}));
      mag_r <= sum_w[53] ? 54'(-sum_w) : 54'(sum_w);
      sgn_r <= sum_w[53];
      phi_r <= {10'd0, mag_r[53:32]} * {22'd0, inv_count_r};
      plo_r <= lop_w[63:32];
      sgn2_r <= sgn_r;
      g_r   <= g_nxt;
      pre_r <= {32'd0, are_w} * {32'd0, ag_w};
      pim_r <= {32'd0, aim_w} * {32'd0, ag_w};
      nre_r <= s35.re[31] != g_r[31];
      nim_r <= s35.im[31] != g_r[31];
      g2_r  <= g_r;
      out_r.kernel_weight <= g2_r;
      out_r.damped_re <= s36.active ? sat(dre_w) : sat(35'(s36.re));
      out_r.damped_im <= s36.active ? sat(dim_w) : sat(35'(s36.im));
    end
  end

  assign out_data = out_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

  a_shift: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> vld_r[LAST] == $past(vld_r[LAST-1]))
    else $error("valid lost in pipeline");

  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !side_r[LAST].active |-> out_data.kernel_weight == jkd_pkg::ONE_Q30)
    else $error("pass-through weight not one");

endmodule
